@@ rtl/marker_watershed_flood_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the marker watershed flood unit
// Shared wrappers that keep every concurrent check in one house form.
// ---------------------------------------------------------------------------
`ifndef MARKER_WATERSHED_FLOOD_UNIT_ASSERT_SVH
`define MARKER_WATERSHED_FLOOD_UNIT_ASSERT_SVH

// Check that is switched off while reset is high.
`define MWF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs through reset.
`define MWF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mwf_pkg.sv @@
// ---------------------------------------------------------------------------
// mwf_pkg
// Types and codes shared by the marker watershed flood unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

  // Input mode codes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FLOOD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  // Reply kinds.
  localparam logic REPLY_FLOOD = 1'b0;
  localparam logic REPLY_LABEL = 1'b1;

  localparam logic [8:0] DIM_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_FLOOD,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        in_range;
    logic [15:0] idx;
    logic [7:0]  gradient;
    logic [15:0] marker;
  } cmd_t;

  typedef enum logic [1:0] {
    NB_RIGHT,
    NB_LEFT,
    NB_BELOW,
    NB_ABOVE
  } nb_dir_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FL_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END,
    ST_LVL_RD,
    ST_LVL_CHK,
    ST_POP,
    ST_NB,
    ST_NB_CHK,
    ST_PUSH,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/mwf_ram.sv @@
// ---------------------------------------------------------------------------
// mwf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/mwf_front.sv @@
// ---------------------------------------------------------------------------
// mwf_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_front #(
  parameter int NPIX = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    mode,
  input  wire logic [15:0]   pixel_index,
  input  wire logic [7:0]    gradient,
  input  wire logic [15:0]   marker,
  output logic               cmd_valid,
  output mwf_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);

  mwf_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  mwf_pkg::cmd_t incoming;
  logic          keep;
  logic          push;

  // Mode three is taken and dropped here.
  always_comb begin
    incoming.idx      = pixel_index;
    incoming.gradient = gradient;
    incoming.marker   = marker;
    incoming.in_range = (32'(pixel_index) < 32'(NPIX));
    incoming.kind     = mwf_pkg::CMD_WRITE;
    keep              = 1'b1;
    unique case (mode)
      mwf_pkg::MODE_WRITE: incoming.kind = mwf_pkg::CMD_WRITE;
      mwf_pkg::MODE_FLOOD: incoming.kind = mwf_pkg::CMD_FLOOD;
      mwf_pkg::MODE_READ:  incoming.kind = mwf_pkg::CMD_READ;
      default:             keep = 1'b0;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready && keep;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= incoming;
        wr_ptr        <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/mwf_back.sv @@
// ---------------------------------------------------------------------------
// mwf_back
// Carries out pixel writes, label reads and the hierarchical-queue flood.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_back #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int LEVELS      = 256,
  parameter int LABEL_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [8:0]    rows,
  input  wire logic [8:0]    cols,
  input  wire logic          cmd_valid,
  input  wire mwf_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               reply_kind,
  output logic [15:0]        label_out
);

  localparam int NPIX = MAX_ROWS * MAX_COLS;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int NW   = $clog2(NPIX + 1);
  localparam int LVW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int YW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int XW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CDW  = YW + XW;
  localparam int DRW  = $clog2(MAX_ROWS + 1);
  localparam int DCW  = $clog2(MAX_COLS + 1);
  localparam int LW   = LABEL_WIDTH;
  localparam logic [LVW-1:0] TOP_LEVEL = LVW'(LEVELS - 1);

  mwf_pkg::back_state_t state, state_next;

  // Sizes and counters of the current flood.
  logic [DRW-1:0] nr;
  logic [DCW-1:0] nc;
  logic [NW-1:0]  npix;
  logic [NW-1:0]  p;
  logic [YW-1:0]  sy;
  logic [XW-1:0]  sx;
  logic           seed_any;
  logic [AW-1:0]  seed_head;
  logic [AW-1:0]  seed_tail;
  logic [LVW-1:0] cur;
  logic [LVW-1:0] clr;
  logic [AW-1:0]  q;
  logic [AW-1:0]  qt;
  logic [YW-1:0]  qy;
  logic [XW-1:0]  qx;
  logic [LW-1:0]  qlabel;
  mwf_pkg::nb_dir_t nb;
  logic [AW-1:0]  t;
  logic [YW-1:0]  ty;
  logic [XW-1:0]  tx;
  logic [LVW-1:0] g;
  logic           rd_ok;

  // RAM ports.
  logic           grad_we, lab_we, link_we, coord_we, head_we, tail_we, ne_we;
  logic [AW-1:0]  grad_wa, lab_wa, link_wa, coord_wa;
  logic [AW-1:0]  grad_ra, lab_ra, link_ra, coord_ra;
  logic [LVW-1:0] head_wa, tail_wa, ne_wa, head_ra, tail_ra, ne_ra;
  logic [7:0]     grad_wd, grad_rd;
  logic [LW-1:0]  lab_wd, lab_rd;
  logic [AW-1:0]  link_wd, link_rd, head_wd, head_rd, tail_wd, tail_rd;
  logic [CDW-1:0] coord_wd, coord_rd;
  logic           ne_wd, ne_rd;

  // Derived combinational values.
  logic [DRW-1:0] nr_sat;
  logic [DCW-1:0] nc_sat;
  logic [AW-1:0]  cmd_addr;
  logic           nb_ok;
  logic [AW-1:0]  nb_addr;
  logic [YW-1:0]  nb_y;
  logic [XW-1:0]  nb_x;
  logic [LVW-1:0] gcalc;
  logic [31:0]    gwide;
  logic           nb_last;
  logic           scan_hit;

  assign nr_sat   = (32'(rows) > 32'(MAX_ROWS)) ? DRW'(MAX_ROWS) : DRW'(rows);
  assign nc_sat   = (32'(cols) > 32'(MAX_COLS)) ? DCW'(MAX_COLS) : DCW'(cols);
  assign cmd_addr = AW'(cmd.idx);
  assign nb_last  = (nb == mwf_pkg::NB_ABOVE);
  assign scan_hit = (lab_rd != '0);

  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = q;
    nb_y    = qy;
    nb_x    = qx;
    unique case (nb)
      mwf_pkg::NB_RIGHT: begin
        nb_ok   = (32'(qx) + 32'd1 < 32'(nc));
        nb_addr = q + AW'(nr);
        nb_x    = qx + XW'(1);
      end
      mwf_pkg::NB_LEFT: begin
        nb_ok   = (qx != '0);
        nb_addr = q - AW'(nr);
        nb_x    = qx - XW'(1);
      end
      mwf_pkg::NB_BELOW: begin
        nb_ok   = (32'(qy) + 32'd1 < 32'(nr));
        nb_addr = q + AW'(1);
        nb_y    = qy + YW'(1);
      end
      mwf_pkg::NB_ABOVE: begin
        nb_ok   = (qy != '0);
        nb_addr = q - AW'(1);
        nb_y    = qy - YW'(1);
      end
      default: ;
    endcase
  end

  // Queue level of a newly reached pixel: its gradient, clipped to the top
  // level and never below the level being flooded.
  always_comb begin
    gwide = 32'(grad_rd);
    if (gwide > 32'(LEVELS - 1)) begin
      gwide = 32'(LEVELS - 1);
    end
    if (gwide < 32'(cur)) begin
      gwide = 32'(cur);
    end
    gcalc = LVW'(gwide);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mwf_pkg::ST_CLEAR:    if (clr == TOP_LEVEL) state_next = mwf_pkg::ST_IDLE;
      mwf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            mwf_pkg::CMD_FLOOD: state_next = mwf_pkg::ST_FL_INIT;
            mwf_pkg::CMD_READ:  if (!out_valid) state_next = mwf_pkg::ST_READ;
            default:            state_next = mwf_pkg::ST_IDLE;
          endcase
        end
      end
      mwf_pkg::ST_READ:     state_next = mwf_pkg::ST_IDLE;
      mwf_pkg::ST_FL_INIT:  state_next = mwf_pkg::ST_SCAN_RD;
      mwf_pkg::ST_SCAN_RD:  state_next = (p == npix) ? mwf_pkg::ST_SCAN_END
                                                     : mwf_pkg::ST_SCAN_CHK;
      mwf_pkg::ST_SCAN_CHK: state_next = mwf_pkg::ST_SCAN_RD;
      mwf_pkg::ST_SCAN_END: state_next = mwf_pkg::ST_LVL_RD;
      mwf_pkg::ST_LVL_RD:   state_next = mwf_pkg::ST_LVL_CHK;
      mwf_pkg::ST_LVL_CHK: begin
        if (ne_rd) begin
          state_next = mwf_pkg::ST_POP;
        end else if (cur == TOP_LEVEL) begin
          state_next = mwf_pkg::ST_DONE;
        end else begin
          state_next = mwf_pkg::ST_LVL_RD;
        end
      end
      mwf_pkg::ST_POP:      state_next = mwf_pkg::ST_NB;
      mwf_pkg::ST_NB: begin
        if (nb_ok) begin
          state_next = mwf_pkg::ST_NB_CHK;
        end else if (nb_last) begin
          state_next = mwf_pkg::ST_LVL_RD;
        end
      end
      mwf_pkg::ST_NB_CHK: begin
        if (lab_rd == '0) begin
          state_next = mwf_pkg::ST_PUSH;
        end else begin
          state_next = nb_last ? mwf_pkg::ST_LVL_RD : mwf_pkg::ST_NB;
        end
      end
      mwf_pkg::ST_PUSH:     state_next = nb_last ? mwf_pkg::ST_LVL_RD : mwf_pkg::ST_NB;
      mwf_pkg::ST_DONE:     if (!out_valid) state_next = mwf_pkg::ST_IDLE;
      default:              state_next = mwf_pkg::ST_IDLE;
    endcase
  end

  // RAM controls and queue pop.
  always_comb begin
    cmd_pop  = 1'b0;
    grad_we  = 1'b0;  grad_wa  = cmd_addr; grad_wd = cmd.gradient; grad_ra = nb_addr;
    lab_we   = 1'b0;  lab_wa   = cmd_addr; lab_wd  = LW'(cmd.marker);
    lab_ra   = cmd_addr;
    link_we  = 1'b0;  link_wa  = seed_tail; link_wd = p[AW-1:0]; link_ra = head_rd;
    coord_we = 1'b0;  coord_wa = p[AW-1:0]; coord_wd = {sy, sx}; coord_ra = head_rd;
    head_we  = 1'b0;  head_wa  = '0; head_wd = seed_head; head_ra = cur;
    tail_we  = 1'b0;  tail_wa  = '0; tail_wd = seed_tail; tail_ra = cur;
    ne_we    = 1'b0;  ne_wa    = clr; ne_wd = 1'b0; ne_ra = cur;
    unique case (state)
      mwf_pkg::ST_CLEAR: ne_we = 1'b1;
      mwf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = (cmd.kind != mwf_pkg::CMD_READ) || !out_valid;
          if (cmd.kind == mwf_pkg::CMD_WRITE && cmd.in_range) begin
            grad_we = 1'b1;
            lab_we  = 1'b1;
          end
        end
      end
      mwf_pkg::ST_SCAN_RD: lab_ra = p[AW-1:0];
      mwf_pkg::ST_SCAN_CHK: begin
        if (scan_hit) begin
          coord_we = 1'b1;
          link_we  = seed_any;
        end
      end
      mwf_pkg::ST_SCAN_END: begin
        head_we = seed_any;
        tail_we = seed_any;
        ne_we   = seed_any;
        ne_wa   = '0;
        ne_wd   = 1'b1;
      end
      mwf_pkg::ST_LVL_CHK: lab_ra = head_rd;
      mwf_pkg::ST_POP: begin
        if (q == qt) begin
          ne_we = 1'b1;
          ne_wa = cur;
          ne_wd = 1'b0;
        end else begin
          head_we = 1'b1;
          head_wa = cur;
          head_wd = link_rd;
        end
      end
      mwf_pkg::ST_NB: lab_ra = nb_addr;
      mwf_pkg::ST_NB_CHK: begin
        ne_ra   = gcalc;
        tail_ra = gcalc;
        if (lab_rd == '0) begin
          lab_we   = 1'b1;
          lab_wa   = t;
          lab_wd   = qlabel;
          coord_we = 1'b1;
          coord_wa = t;
          coord_wd = {ty, tx};
        end
      end
      mwf_pkg::ST_PUSH: begin
        tail_we = 1'b1;
        tail_wa = g;
        tail_wd = t;
        if (!ne_rd) begin
          head_we = 1'b1;
          head_wa = g;
          head_wd = t;
          ne_we   = 1'b1;
          ne_wa   = g;
          ne_wd   = 1'b1;
        end else begin
          link_we = 1'b1;
          link_wa = tail_rd;
          link_wd = t;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwf_pkg::ST_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mwf_pkg::ST_CLEAR: clr <= clr + LVW'(1);
        mwf_pkg::ST_IDLE: begin
          if (cmd_valid && cmd.kind == mwf_pkg::CMD_FLOOD) begin
            nr <= nr_sat;
            nc <= nc_sat;
          end
          rd_ok <= cmd.in_range;
        end
        mwf_pkg::ST_READ: begin
          out_valid  <= 1'b1;
          reply_kind <= mwf_pkg::REPLY_LABEL;
          label_out  <= rd_ok ? 16'(lab_rd) : 16'd0;
        end
        mwf_pkg::ST_FL_INIT: begin
          npix     <= NW'(32'(nr) * 32'(nc));
          p        <= '0;
          sy       <= '0;
          sx       <= '0;
          seed_any <= 1'b0;
        end
        mwf_pkg::ST_SCAN_CHK: begin
          if (scan_hit) begin
            if (!seed_any) begin
              seed_head <= p[AW-1:0];
            end
            seed_tail <= p[AW-1:0];
            seed_any  <= 1'b1;
          end
          p <= p + NW'(1);
          if (32'(sy) + 32'd1 == 32'(nr)) begin
            sy <= '0;
            sx <= sx + XW'(1);
          end else begin
            sy <= sy + YW'(1);
          end
        end
        mwf_pkg::ST_SCAN_END: cur <= '0;
        mwf_pkg::ST_LVL_CHK: begin
          if (ne_rd) begin
            q  <= head_rd;
            qt <= tail_rd;
          end else if (cur != TOP_LEVEL) begin
            cur <= cur + LVW'(1);
          end
        end
        mwf_pkg::ST_POP: begin
          qlabel <= lab_rd;
          qy     <= coord_rd[CDW-1:XW];
          qx     <= coord_rd[XW-1:0];
          nb     <= mwf_pkg::NB_RIGHT;
        end
        mwf_pkg::ST_NB: begin
          if (nb_ok) begin
            t  <= nb_addr;
            ty <= nb_y;
            tx <= nb_x;
          end else begin
            nb <= mwf_pkg::nb_dir_t'(nb + 2'd1);
          end
        end
        mwf_pkg::ST_NB_CHK: begin
          if (lab_rd == '0) begin
            g <= gcalc;
          end else begin
            nb <= mwf_pkg::nb_dir_t'(nb + 2'd1);
          end
        end
        mwf_pkg::ST_PUSH: nb <= mwf_pkg::nb_dir_t'(nb + 2'd1);
        mwf_pkg::ST_DONE: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            reply_kind <= mwf_pkg::REPLY_FLOOD;
            label_out  <= 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  mwf_ram #(.WIDTH(8), .DEPTH(NPIX)) u_grad (
    .clk(clk), .we(grad_we), .waddr(grad_wa), .wdata(grad_wd),
    .raddr(grad_ra), .rdata(grad_rd));

  mwf_ram #(.WIDTH(LW), .DEPTH(NPIX)) u_label (
    .clk(clk), .we(lab_we), .waddr(lab_wa), .wdata(lab_wd),
    .raddr(lab_ra), .rdata(lab_rd));

  mwf_ram #(.WIDTH(AW), .DEPTH(NPIX)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(link_ra), .rdata(link_rd));

  mwf_ram #(.WIDTH(CDW), .DEPTH(NPIX)) u_coord (
    .clk(clk), .we(coord_we), .waddr(coord_wa), .wdata(coord_wd),
    .raddr(coord_ra), .rdata(coord_rd));

  mwf_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd));

  mwf_ram #(.WIDTH(AW), .DEPTH(LEVELS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
    .raddr(tail_ra), .rdata(tail_rd));

  mwf_ram #(.WIDTH(1), .DEPTH(LEVELS)) u_nonempty (
    .clk(clk), .we(ne_we), .waddr(ne_wa), .wdata(ne_wd),
    .raddr(ne_ra), .rdata(ne_rd));

endmodule

`default_nettype wire

@@ rtl/marker_watershed_flood_unit.sv @@
// ---------------------------------------------------------------------------
// marker_watershed_flood_unit
// Marker-controlled watershed by hierarchical FIFO queues, one per level.
// ---------------------------------------------------------------------------
// Timing: a label read passes the request queue, a registered label memory
// read and the reply register; a flood scans every pixel, then works through
// the levels, its pace set by one read port per memory. Throughput: one write
// per cycle while the sequencer is idle; no read is taken while a reply waits,
// but the two-entry request queue keeps taking requests until it is full.
// Reset: synchronous; then a pass over every level clears the level occupancy.
`default_nettype none

module marker_watershed_flood_unit #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int LEVELS      = 256,
  parameter int LABEL_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] pixel_index,
  input  wire logic [7:0]  gradient,
  input  wire logic [15:0] marker,
  // Reply channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             reply_kind,
  output logic [15:0]      label_out,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  // The image size registers. Values beyond the stored maximum saturate
  // when a flood starts, so they are kept here exactly as written.
  logic [8:0] rows;
  logic [8:0] cols;

  mwf_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= mwf_pkg::DIM_RESET;
      cols <= mwf_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == mwf_pkg::REG_ROWS) begin
        rows <= cfg_data;
      end
      if (cfg_index == mwf_pkg::REG_COLS) begin
        cols <= cfg_data;
      end
    end
  end

  // The front end decodes the mode, flags writes and reads that fall
  // outside the image memories, and queues the requests.
  mwf_front #(.NPIX(MAX_ROWS * MAX_COLS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .pixel_index (pixel_index),
    .gradient    (gradient),
    .marker      (marker),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // The back end owns all memories: gradients, labels, queue links, the
  // coordinates of queued pixels, and the per-level head, tail and
  // occupancy. It runs the flood as a sequencer and holds the reply.
  mwf_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .LEVELS      (LEVELS),
    .LABEL_WIDTH (LABEL_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .rows       (rows),
    .cols       (cols),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reply_kind (reply_kind),
    .label_out  (label_out)
  );

endmodule

`default_nettype wire

@@ rtl/mwf_checker.sv @@
// ---------------------------------------------------------------------------
// mwf_checker
// Port-level checks for the marker watershed flood unit.
// ---------------------------------------------------------------------------
`default_nettype none

`include "marker_watershed_flood_unit_assert.svh"

module mwf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        reply_kind,
  input wire logic [15:0] label_out,
  input wire logic        cfg_ready
);

  `MWF_ASSERT(a_reply_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(reply_kind) && $stable(label_out), "reply changed while stalled")
  `MWF_ASSERT(a_flood_zero, clk, rst, out_valid && reply_kind == mwf_pkg::REPLY_FLOOD |-> label_out == 16'd0, "flood reply carries a label")
  `MWF_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "reply valid after reset")
  `MWF_ASSERT(a_cfg_ready, clk, rst, cfg_ready, "configuration port not ready")

endmodule

bind marker_watershed_flood_unit mwf_checker u_mwf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .reply_kind (reply_kind),
  .label_out  (label_out),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

@@ dv/mwf_flood_checker.sv @@
// ---------------------------------------------------------------------------
// Flood unit checker
// Watches the request, reply and register channels of the watershed flood
// unit. It keeps its own gradient and basin images, floods them on each
// flood request, and compares every reply with the oldest one predicted.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_flood_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] pixel_index,
  input  wire logic [7:0]  gradient,
  input  wire logic [15:0] marker,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        reply_kind,
  input  wire logic [15:0] label_out,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_LEVELS = 256;
  localparam int unsigned DIM_MAX    = 256;

  typedef struct {
    logic        kind;
    logic [15:0] label;
  } reply_t;

  logic [7:0]  grad_mem  [65536];
  logic [15:0] basin_mem [65536];
  int unsigned level_q   [NUM_LEVELS][$];
  int unsigned dim_rows;
  int unsigned dim_cols;
  reply_t      replies_due[$];
  int          mismatches;

  assign errors  = mismatches;
  assign pending = replies_due.size();

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // A neighbour still unlabeled joins the basin of the popped pixel.
  function automatic void claim(input int unsigned from, input int unsigned to,
                                input int unsigned lvl);
    int unsigned g;
    if (basin_mem[to] != 16'd0) return;
    basin_mem[to] = basin_mem[from];
    g = grad_mem[to];
    if (g < lvl) g = lvl;
    level_q[g].push_back(to);
  endfunction

  function automatic void flood_basins();
    int unsigned nr, nc, n, q, y, x, lvl;
    for (int l = 0; l < NUM_LEVELS; l++) level_q[l].delete();
    nr = (dim_rows > DIM_MAX) ? DIM_MAX : dim_rows;
    nc = (dim_cols > DIM_MAX) ? DIM_MAX : dim_cols;
    n  = nr * nc;
    if (n == 0) return;
    for (int unsigned p = 0; p < n; p++)
      if (basin_mem[p] != 16'd0) level_q[0].push_back(p);
    lvl = 0;
    while (lvl < NUM_LEVELS) begin
      if (level_q[lvl].size() != 0) begin
        q = level_q[lvl].pop_front();
        y = q % nr;
        x = q / nr;
        if (x + 1 < nc) claim(q, q + nr, lvl);
        if (x > 0)      claim(q, q - nr, lvl);
        if (y + 1 < nr) claim(q, q + 1, lvl);
        if (y > 0)      claim(q, q - 1, lvl);
      end else begin
        lvl++;
      end
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      dim_rows = 256;
      dim_cols = 256;
      replies_due.delete();
    end else begin
      // Replies first: a request taken at this edge cannot answer at it.
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("reply kind %0d label %0h with none due",
                                    reply_kind, label_out));
        end else begin
          want = replies_due.pop_front();
          if (reply_kind !== want.kind)
            report_mismatch($sformatf("reply_kind %0d, want %0d", reply_kind, want.kind));
          if (label_out !== want.label)
            report_mismatch($sformatf("label_out %0h, want %0h", label_out, want.label));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mwf_pkg::REG_ROWS) dim_rows = cfg_data;
        else if (cfg_index == mwf_pkg::REG_COLS) dim_cols = cfg_data;
      end
      if (in_valid && in_ready) begin
        case (mode)
          mwf_pkg::MODE_WRITE: begin
            grad_mem[pixel_index]  = gradient;
            basin_mem[pixel_index] = marker;
          end
          mwf_pkg::MODE_FLOOD: begin
            flood_basins();
            want.kind  = mwf_pkg::REPLY_FLOOD;
            want.label = 16'd0;
            replies_due.push_back(want);
          end
          mwf_pkg::MODE_READ: begin
            want.kind  = mwf_pkg::REPLY_LABEL;
            want.label = basin_mem[pixel_index];
            replies_due.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_marker_watershed_flood_unit.sv @@
// ---------------------------------------------------------------------------
// Watershed flood unit testbench
// Loads small images in many shapes, floods them from random seed labels and
// reads labels back, with random gaps on both channels and one long reply
// stall. Prediction and checking live in the checker instantiated beside
// the unit.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_marker_watershed_flood_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth mode code is not defined by the unit and must be dropped.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1800;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TIME  = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [15:0] pixel_index;
  logic [7:0]  gradient;
  logic [15:0] marker;
  logic        out_valid;
  logic        out_ready;
  logic        reply_kind;
  logic [15:0] label_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int errors;
  int pending;

  // Both sides stop idling while calm is set; hold_req asks the reply side
  // for one long stall.
  bit calm;
  bit hold_req;
  int items_sent;
  int cycles;

  // Pixels that have been written at least once. Reads and floods only ever
  // touch these, since a fresh pixel's contents are undefined.
  bit          written [65536];
  int unsigned written_list[$];

  marker_watershed_flood_unit u_dut (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .pixel_index, .gradient, .marker,
    .out_valid, .out_ready, .reply_kind, .label_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mwf_flood_checker u_checker (
    .clk, .rst,
    .in_valid, .in_ready, .mode, .pixel_index, .gradient, .marker,
    .out_valid, .out_ready, .reply_kind, .label_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: the limit leaves a wide margin over the whole run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reply side. Random stalls, none while calm, and one long hold-off when
  // asked so the request queue fills and the unit pushes back.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // Offer one request and wait until it is taken. Idle gaps drop valid
  // before it; otherwise the next request follows the last one directly.
  task automatic send_req(input logic [1:0] m, input logic [15:0] idx,
                          input logic [7:0] g, input logic [15:0] mk);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    pixel_index <= idx;
    gradient    <= g;
    marker      <= mk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_px(input logic [15:0] idx, input logic [7:0] g,
                          input logic [15:0] mk);
    send_req(mwf_pkg::MODE_WRITE, idx, g, mk);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [8:0] d);
    while ($urandom_range(0, 99) < 32) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the unit idle. Writes give no reply, so a
  // short pause covers any write still in the request queue.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_grad();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_seed(input int pct);
    if ($urandom_range(0, 99) >= pct) return 16'd0;
    case ($urandom_range(0, 7))
      0:       return 16'hFFFF;
      1:       return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_read(input int unsigned n);
    if (n != 0 && $urandom_range(0, 3) != 0) return 16'($urandom_range(0, n - 1));
    return 16'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // One image: set the shape, load every pixel in random order, add some
  // stray writes, flood, then read labels back. Sometimes the image is
  // flooded a second time so the earlier basins act as seeds.
  task automatic run_image(input int r, input int c, input int seed_pct,
                           input int n_reads, input bit stall);
    int unsigned nr, nc, n;
    int unsigned order[$];
    settle();
    write_cfg(mwf_pkg::REG_ROWS, 9'(r));
    write_cfg(mwf_pkg::REG_COLS, 9'(c));
    nr = (r > 256) ? 256 : r;
    nc = (c > 256) ? 256 : c;
    n  = nr * nc;
    for (int unsigned k = 0; k < n; k++) order.push_back(k);
    order.shuffle();
    foreach (order[k]) write_px(16'(order[k]), pick_grad(), pick_seed(seed_pct));
    repeat ($urandom_range(0, 4))
      write_px(16'($urandom), 8'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0)
      send_req(MODE_UNUSED, 16'($urandom), 8'($urandom), 16'($urandom));
    send_req(mwf_pkg::MODE_FLOOD, 16'($urandom), 8'($urandom), 16'($urandom));
    if (stall) hold_req = 1'b1;
    repeat (n_reads)
      send_req(mwf_pkg::MODE_READ, pick_read(n), 8'($urandom), 16'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      send_req(mwf_pkg::MODE_FLOOD, 16'($urandom), 8'($urandom), 16'($urandom));
      repeat (n_reads / 2 + 1)
        send_req(mwf_pkg::MODE_READ, pick_read(n), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int r, c;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = mwf_pkg::MODE_WRITE;
    pixel_index = '0;
    gradient    = '0;
    marker      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = mwf_pkg::REG_ROWS;
    cfg_data    = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: a 4 x 3 image with the field extremes, the top pixel index,
    // an undefined mode, one flood and reads of every interesting pixel.
    settle();
    write_cfg(mwf_pkg::REG_ROWS, 9'd4);
    write_cfg(mwf_pkg::REG_COLS, 9'd3);
    write_px(16'd0,  8'd255, 16'hFFFF);
    write_px(16'd1,  8'd0,   16'd0);
    write_px(16'd2,  8'd255, 16'd0);
    write_px(16'd3,  8'd0,   16'd0);
    write_px(16'd4,  8'd128, 16'd0);
    write_px(16'd5,  8'd255, 16'd0);
    write_px(16'd6,  8'd7,   16'd0);
    write_px(16'd7,  8'd0,   16'd0);
    write_px(16'd8,  8'd200, 16'd0);
    write_px(16'd9,  8'd0,   16'd0);
    write_px(16'd10, 8'd1,   16'd0);
    write_px(16'd11, 8'd0,   16'd1);
    write_px(16'hFFFF, 8'hAA, 16'h5555);
    send_req(MODE_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_req(mwf_pkg::MODE_FLOOD, 16'd0, 8'd0, 16'd0);
    send_req(mwf_pkg::MODE_READ, 16'd0,  8'd0, 16'd0);
    send_req(mwf_pkg::MODE_READ, 16'd5,  8'd0, 16'd0);
    send_req(mwf_pkg::MODE_READ, 16'd6,  8'd0, 16'd0);
    send_req(mwf_pkg::MODE_READ, 16'd11, 8'd0, 16'd0);
    send_req(mwf_pkg::MODE_READ, 16'hFFFF, 8'd0, 16'd0);

    // Shape extremes: a single column and row at full size, sizes past the
    // maximum that saturate, empty images and a single pixel.
    run_image(256, 1,   4, 12, 1'b0);
    run_image(1,   256, 4, 12, 1'b0);
    run_image(300, 1,   3, 8,  1'b0);
    run_image(1,   511, 3, 8,  1'b0);
    run_image(0,   5,   10, 6, 1'b0);
    run_image(5,   0,   10, 6, 1'b0);
    run_image(1,   1,   50, 4, 1'b0);
    // Long reply stall while reads keep coming.
    run_image(6,   6,   10, 40, 1'b1);

    // Random small images; one stretch runs with no idling on either side.
    while (items_sent < ITEM_TARGET) begin
      r = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) % 40 : $urandom_range(1, 12);
      c = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 511) % 40 : $urandom_range(1, 12);
      calm = (items_sent > 900 && items_sent < 1150);
      run_image(r, c, $urandom_range(2, 25), $urandom_range(4, 20), 1'b0);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
